>>> rtl/core/lpi_pkg.sv
// Shared constants for the two-line intersection block.
// No dependencies.
`timescale 1ns / 1ps

package lpi_pkg;

    // Width of the fixed-point output coordinates.
    localparam int OUT_WIDTH = 48;

    localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
    localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};

endpackage

>>> rtl/core/lpi_coef.sv
// Two-stage line coefficient unit: a, b in stage one, c = -x*a - y*b in stage two.
// Depends on lpi_pkg.
`timescale 1ns / 1ps

module lpi_coef
    import lpi_pkg::*;
#(
    parameter int CW = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [CW-1:0]     p0x,
    input  logic signed [CW-1:0]     p0y,
    input  logic signed [CW-1:0]     p1x,
    input  logic signed [CW-1:0]     p1y,
    input  logic signed [CW-1:0]     q0x,
    input  logic signed [CW-1:0]     q0y,
    input  logic signed [CW-1:0]     q1x,
    input  logic signed [CW-1:0]     q1y,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [CW:0]       a1,
    output logic signed [CW:0]       b1,
    output logic signed [2*CW+1:0]   c1,
    output logic signed [CW:0]       a2,
    output logic signed [CW:0]       b2,
    output logic signed [2*CW+1:0]   c2
);

    localparam int AW  = CW + 1;
    localparam int CCW = 2 * CW + 2;

    typedef struct packed {
        logic signed [AW-1:0] a;
        logic signed [AW-1:0] b;
    } ab_t;

    // Horizontal and vertical lines get unit coefficients.
    function automatic ab_t line_ab(input logic signed [CW-1:0] px,
                                    input logic signed [CW-1:0] py,
                                    input logic signed [CW-1:0] qx,
                                    input logic signed [CW-1:0] qy);
        ab_t r;
        if (py == qy)
        begin
            r.a = '0;
            if (qx > px)
                r.b = AW'(1);
            else if (qx == px)
                r.b = '0;
            else
                r.b = {AW{1'b1}};
        end
        else if (qx == px)
        begin
            r.b = '0;
            r.a = (qy > py) ? {AW{1'b1}} : AW'(1);
        end
        else
        begin
            r.a = $signed({py[CW-1], py}) - $signed({qy[CW-1], qy});
            r.b = $signed({qx[CW-1], qx}) - $signed({px[CW-1], px});
        end
        return r;
    endfunction

    logic              v1_reg, v2_reg;
    logic              rdy1, rdy2;
    ab_t               l1_reg, l2_reg;
    logic signed [CW-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [AW-1:0] a1_reg, b1_reg, a2_reg, b2_reg;
    logic signed [CCW-1:0] c1_reg, c2_reg;
    logic signed [CCW-1:0] pa1, pb1, pa2, pb2;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
        end
    end

    assign pa1 = x1_reg * l1_reg.a;
    assign pb1 = y1_reg * l1_reg.b;
    assign pa2 = x2_reg * l2_reg.a;
    assign pb2 = y2_reg * l2_reg.b;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            l1_reg <= line_ab(p0x, p0y, p1x, p1y);
            l2_reg <= line_ab(q0x, q0y, q1x, q1y);
            x1_reg <= p0x;
            y1_reg <= p0y;
            x2_reg <= q0x;
            y2_reg <= q0y;
        end
        if (rdy2)
        begin
            a1_reg <= l1_reg.a;
            b1_reg <= l1_reg.b;
            a2_reg <= l2_reg.a;
            b2_reg <= l2_reg.b;
            c1_reg <= -pa1 - pb1;
            c2_reg <= -pa2 - pb2;
        end
    end

    assign out_valid = v2_reg;
    assign a1 = a1_reg;
    assign b1 = b1_reg;
    assign c1 = c1_reg;
    assign a2 = a2_reg;
    assign b2 = b2_reg;
    assign c2 = c2_reg;

endmodule

>>> rtl/core/lpi_cross.sv
// Cramer's rule products and differences: denominator and both numerators, two stages.
// Depends on lpi_pkg.
`timescale 1ns / 1ps

module lpi_cross
    import lpi_pkg::*;
#(
    parameter int CW = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [CW:0]       a1,
    input  logic signed [CW:0]       b1,
    input  logic signed [2*CW+1:0]   c1,
    input  logic signed [CW:0]       a2,
    input  logic signed [CW:0]       b2,
    input  logic signed [2*CW+1:0]   c2,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [2*CW+2:0]   den,
    output logic signed [3*CW+3:0]   num_x,
    output logic signed [3*CW+3:0]   num_y
);

    localparam int DPW = 2 * CW + 2;
    localparam int NPW = 3 * CW + 3;

    logic v1_reg, v2_reg, rdy1, rdy2;
    logic signed [DPW-1:0] p_a1b2_reg, p_a2b1_reg;
    logic signed [NPW-1:0] p_b1c2_reg, p_b2c1_reg, p_a2c1_reg, p_a1c2_reg;
    logic signed [DPW-1:0] p_a1b2_next, p_a2b1_next;
    logic signed [NPW-1:0] p_b1c2_next, p_b2c1_next, p_a2c1_next, p_a1c2_next;
    logic signed [DPW:0]   den_reg;
    logic signed [NPW:0]   nx_reg, ny_reg;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign p_a1b2_next = a1 * b2;
    assign p_a2b1_next = a2 * b1;
    assign p_b1c2_next = b1 * c2;
    assign p_b2c1_next = b2 * c1;
    assign p_a2c1_next = a2 * c1;
    assign p_a1c2_next = a1 * c2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            p_a1b2_reg <= p_a1b2_next;
            p_a2b1_reg <= p_a2b1_next;
            p_b1c2_reg <= p_b1c2_next;
            p_b2c1_reg <= p_b2c1_next;
            p_a2c1_reg <= p_a2c1_next;
            p_a1c2_reg <= p_a1c2_next;
        end
        if (rdy2)
        begin
            den_reg <= (DPW+1)'(p_a1b2_reg) - (DPW+1)'(p_a2b1_reg);
            nx_reg  <= (NPW+1)'(p_b1c2_reg) - (NPW+1)'(p_b2c1_reg);
            ny_reg  <= (NPW+1)'(p_a2c1_reg) - (NPW+1)'(p_a1c2_reg);
        end
    end

    assign out_valid = v2_reg;
    assign den       = den_reg;
    assign num_x     = nx_reg;
    assign num_y     = ny_reg;

endmodule

>>> rtl/core/lpi_div.sv
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
// Depends on lpi_pkg.
`timescale 1ns / 1ps

module lpi_div
    import lpi_pkg::*;
#(
    parameter int CW   = 16,
    parameter int FRAC = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [2*CW+2:0]         den,
    input  logic signed [3*CW+3:0]         num_x,
    input  logic signed [3*CW+3:0]         num_y,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [3*CW+3+FRAC-1:0]         quo_x,
    output logic [3*CW+3+FRAC-1:0]         quo_y,
    output logic                           neg_x,
    output logic                           neg_y,
    output logic                           zero
);

    localparam int NMW = 3 * CW + 3;
    localparam int NW  = NMW + FRAC;
    localparam int DMW = 2 * CW + 2;
    localparam int NS  = NW + 1;    // prep stage plus one per quotient bit

    logic            v_reg   [0:NS-1];
    logic            rdy     [0:NS];
    logic [DMW-1:0]  dm_reg  [0:NS-1];
    logic [DMW-1:0]  rx_reg  [0:NS-1];
    logic [DMW-1:0]  ry_reg  [0:NS-1];
    logic [NW-1:0]   qx_reg  [0:NS-1];
    logic [NW-1:0]   qy_reg  [0:NS-1];
    logic            nx_reg  [0:NS-1];
    logic            ny_reg  [0:NS-1];
    logic            z_reg   [0:NS-1];

    logic [NMW:0]    mag_x, mag_y;
    logic [DMW:0]    mag_d;

    assign mag_x = num_x[NMW] ? (NMW+1)'(-num_x) : (NMW+1)'(num_x);
    assign mag_y = num_y[NMW] ? (NMW+1)'(-num_y) : (NMW+1)'(num_y);
    assign mag_d = den[DMW] ? (DMW+1)'(-den) : (DMW+1)'(den);

    assign rdy[NS]  = out_ready;
    assign in_ready = rdy[0];

    genvar i;
    generate
        for (i = 0; i < NS; i++)
        begin : g_ctl
            assign rdy[i] = !v_reg[i] || rdy[i+1];
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[i] <= 1'b0;
                else if (rdy[i])
                    v_reg[i] <= (i == 0) ? in_valid : v_reg[i-1 < 0 ? 0 : i-1];
            end
        end

        // Prep stage: magnitudes, signs, zero test.
        always_ff @(posedge clk)
        begin
            if (rdy[0])
            begin
                dm_reg[0] <= mag_d[DMW-1:0];
                rx_reg[0] <= '0;
                ry_reg[0] <= '0;
                qx_reg[0] <= NW'(mag_x[NMW-1:0]) << FRAC;
                qy_reg[0] <= NW'(mag_y[NMW-1:0]) << FRAC;
                nx_reg[0] <= num_x[NMW] ^ den[DMW];
                ny_reg[0] <= num_y[NMW] ^ den[DMW];
                z_reg[0]  <= (den == '0);
            end
        end

        for (i = 1; i < NS; i++)
        begin : g_step
            logic [DMW:0] tx, ty;
            logic         gx, gy;

            assign tx = {rx_reg[i-1], qx_reg[i-1][NW-1]};
            assign ty = {ry_reg[i-1], qy_reg[i-1][NW-1]};
            assign gx = tx >= {1'b0, dm_reg[i-1]};
            assign gy = ty >= {1'b0, dm_reg[i-1]};

            always_ff @(posedge clk)
            begin
                if (rdy[i])
                begin
                    dm_reg[i] <= dm_reg[i-1];
                    rx_reg[i] <= gx ? DMW'(tx - {1'b0, dm_reg[i-1]}) : tx[DMW-1:0];
                    ry_reg[i] <= gy ? DMW'(ty - {1'b0, dm_reg[i-1]}) : ty[DMW-1:0];
                    qx_reg[i] <= {qx_reg[i-1][NW-2:0], gx};
                    qy_reg[i] <= {qy_reg[i-1][NW-2:0], gy};
                    nx_reg[i] <= nx_reg[i-1];
                    ny_reg[i] <= ny_reg[i-1];
                    z_reg[i]  <= z_reg[i-1];
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[NS-1];
    assign quo_x     = qx_reg[NS-1];
    assign quo_y     = qy_reg[NS-1];
    assign neg_x     = nx_reg[NS-1];
    assign neg_y     = ny_reg[NS-1];
    assign zero      = z_reg[NS-1];

endmodule

>>> rtl/core/line_pair_intersection_2d.sv
// Top level of the two-line intersection pipeline.
// Depends on lpi_pkg, lpi_coef, lpi_cross, lpi_div.
`timescale 1ns / 1ps

// Usage
// - Input channel (in_valid / in_ready): one beat carries two lines, each as two
//   signed integer points. Output channel (out_valid / out_ready): one beat per
//   input beat, in order: the crossing point in signed fixed point with FRAC_BITS
//   fraction bits, no_crossing for parallel or degenerate lines (coordinates 0),
//   saturated when a coordinate was clamped to the 48-bit range.
// - Throughput: one beat per cycle while the receiver is ready, fully pipelined.
// - Stages, in order: coefficients, Cramer products, divider prep, one divider
//   stage per quotient bit (3*COORD_WIDTH+3+FRAC_BITS quotient bits), then the
//   saturation / output register. The quotient bit count of the divider sets
//   the depth.
// - Each stage advances when it is empty or its successor advances, so bubbles
//   collapse: a stalled receiver only blocks input once every stage is full.
// - Reset clears all valid bits; data registers are not reset.
module line_pair_intersection_2d
    import lpi_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [COORD_WIDTH-1:0]  first_start_x,
    input  logic signed [COORD_WIDTH-1:0]  first_start_y,
    input  logic signed [COORD_WIDTH-1:0]  first_end_x,
    input  logic signed [COORD_WIDTH-1:0]  first_end_y,
    input  logic signed [COORD_WIDTH-1:0]  second_start_x,
    input  logic signed [COORD_WIDTH-1:0]  second_start_y,
    input  logic signed [COORD_WIDTH-1:0]  second_end_x,
    input  logic signed [COORD_WIDTH-1:0]  second_end_y,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [OUT_WIDTH-1:0]    cross_x,
    output logic signed [OUT_WIDTH-1:0]    cross_y,
    output logic                           no_crossing,
    output logic                           saturated
);

    localparam int CW = COORD_WIDTH;
    localparam int NW = 3 * CW + 3 + FRAC_BITS;
    localparam int QW = ((NW > OUT_WIDTH) ? NW : OUT_WIDTH) + 1;

    // Magnitude limits of the quotient, positive and negative side.
    localparam logic [QW-1:0] POS_LIM = QW'(OUT_MAX);
    localparam logic [QW-1:0] NEG_LIM = POS_LIM + QW'(1);

    // coefficient stage outputs
    logic                  cf_valid, cf_ready;
    logic signed [CW:0]    a1, b1, a2, b2;
    logic signed [2*CW+1:0] c1, c2;

    // Cramer stage outputs
    logic                  cr_valid, cr_ready;
    logic signed [2*CW+2:0] den;
    logic signed [3*CW+3:0] num_x, num_y;

    // divider outputs
    logic                  dv_valid, dv_ready;
    logic [NW-1:0]         quo_x, quo_y;
    logic                  neg_x, neg_y, zero;

    lpi_coef #(.CW(CW)) u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .p0x       (first_start_x),
        .p0y       (first_start_y),
        .p1x       (first_end_x),
        .p1y       (first_end_y),
        .q0x       (second_start_x),
        .q0y       (second_start_y),
        .q1x       (second_end_x),
        .q1y       (second_end_y),
        .out_valid (cf_valid),
        .out_ready (cf_ready),
        .a1        (a1),
        .b1        (b1),
        .c1        (c1),
        .a2        (a2),
        .b2        (b2),
        .c2        (c2)
    );

    lpi_cross #(.CW(CW)) u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cf_valid),
        .in_ready  (cf_ready),
        .a1        (a1),
        .b1        (b1),
        .c1        (c1),
        .a2        (a2),
        .b2        (b2),
        .c2        (c2),
        .out_valid (cr_valid),
        .out_ready (cr_ready),
        .den       (den),
        .num_x     (num_x),
        .num_y     (num_y)
    );

    lpi_div #(.CW(CW), .FRAC(FRAC_BITS)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cr_valid),
        .in_ready  (cr_ready),
        .den       (den),
        .num_x     (num_x),
        .num_y     (num_y),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .quo_x     (quo_x),
        .quo_y     (quo_y),
        .neg_x     (neg_x),
        .neg_y     (neg_y),
        .zero      (zero)
    );

    // Saturation and sign restore.
    logic [QW-1:0]              qx_ext, qy_ext;
    logic signed [OUT_WIDTH-1:0] x_next, y_next;
    logic                       sx, sy;

    assign qx_ext = QW'(quo_x);
    assign qy_ext = QW'(quo_y);

    always_comb
    begin
        sx = 1'b0;
        sy = 1'b0;
        if (neg_x)
        begin
            if (qx_ext > NEG_LIM)
            begin
                x_next = OUT_MIN;
                sx     = 1'b1;
            end
            else
                x_next = OUT_WIDTH'(-qx_ext);
        end
        else if (qx_ext > POS_LIM)
        begin
            x_next = OUT_MAX;
            sx     = 1'b1;
        end
        else
            x_next = OUT_WIDTH'(qx_ext);

        if (neg_y)
        begin
            if (qy_ext > NEG_LIM)
            begin
                y_next = OUT_MIN;
                sy     = 1'b1;
            end
            else
                y_next = OUT_WIDTH'(-qy_ext);
        end
        else if (qy_ext > POS_LIM)
        begin
            y_next = OUT_MAX;
            sy     = 1'b1;
        end
        else
            y_next = OUT_WIDTH'(qy_ext);
    end

    // Output register.
    logic                        ov_reg;
    logic signed [OUT_WIDTH-1:0] x_reg, y_reg;
    logic                        nc_reg, sat_reg;

    assign dv_ready = !ov_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (dv_ready)
            ov_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (dv_ready)
        begin
            // zero denominator: flag only, coordinates cleared
            x_reg   <= zero ? '0 : x_next;
            y_reg   <= zero ? '0 : y_next;
            nc_reg  <= zero;
            sat_reg <= !zero && (sx || sy);
        end
    end

    assign out_valid   = ov_reg;
    assign cross_x     = x_reg;
    assign cross_y     = y_reg;
    assign no_crossing = nc_reg;
    assign saturated   = sat_reg;

endmodule

>>> rtl/core/lpi_check.sv
// Port-level checker for the intersection block, bound to the top level.
// Depends on lpi_pkg and line_pair_intersection_2d.
`timescale 1ns / 1ps

module lpi_check
    import lpi_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic signed [OUT_WIDTH-1:0]  cross_x,
    input logic signed [OUT_WIDTH-1:0]  cross_y,
    input logic                         no_crossing,
    input logic                         saturated
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cross_x) && $stable(cross_y))
        else $error("result beat changed while stalled");

    // No crossing gives zero coordinates and no saturation.
    a_nc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_crossing |-> cross_x == '0 && cross_y == '0 && !saturated)
        else $error("no_crossing beat with nonzero payload");

    // Saturation leaves at least one coordinate on a rail.
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            cross_x == OUT_MAX || cross_x == OUT_MIN ||
            cross_y == OUT_MAX || cross_y == OUT_MIN)
        else $error("saturated without a clamped coordinate");

    // Reset empties the output.
    a_rst_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid || $past(!rst_n) == 1'b0 || rst_n)
        else $error("output valid straight out of reset");

endmodule

bind line_pair_intersection_2d lpi_check u_lpi_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cross_x     (cross_x),
    .cross_y     (cross_y),
    .no_crossing (no_crossing),
    .saturated   (saturated)
);
